@@ rtl/core/ihbl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX block loader package
// Shared types, constants and controller state encoding.
// ----------------------------------------------------------------------------
package ihbl_pkg;

	localparam int unsigned BLOCK_BYTES_DEF = 1024;
	localparam int unsigned NUM_BLOCKS_DEF  = 32;

	localparam logic [7:0] FILL_BYTE  = 8'hff;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_ELA  = 8'h04;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PARSE,
		ST_SEARCH,
		ST_OPEN,
		ST_GAP,
		ST_STORE,
		ST_EOF_WALK,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic parse;       // run the character parser on the held character
		logic search_init; // start a block search
		logic search_step; // advance the search index
		logic search_sel;  // select the block at the search index
		logic open_blk;    // open a new block at the open count
		logic overflow;    // flag a full store, abandon record
		logic gap_write;   // write one fill byte and advance the fill
		logic data_write;  // write the data byte (if room) and finish
		logic eof_init;    // start the end-of-file padding walk
		logic eof_step;    // write one pad byte or move to next block
		logic eof_finish;  // make blocks ready and close them
		logic read_issue;  // issue the memory read
		logic capture;     // load the output register
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic need_store;   // parsed a data byte to store
		logic need_eof;     // parsed an end-of-file trigger
		logic cur_hit;      // current selected block matches the base
		logic search_done;  // search index reached the open count
		logic search_hit;   // search entry matches the base
		logic store_full;   // open count at limit
		logic gap_more;     // fill still below offset
		logic eof_done;     // walk has covered all open blocks
	} stat_t;

endpackage : ihbl_pkg
`default_nettype wire

@@ rtl/core/ihbl_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX block loader controller
// Sequences parsing, block search, gap fill, store, padding walk and reads.
// ----------------------------------------------------------------------------
module ihbl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_fire,
	input  wire logic           in_action,
	input  wire logic           out_busy,
	input  wire ihbl_pkg::stat_t st,
	output      ihbl_pkg::cmd_t  cmd,
	output      logic           idle
);
	import ihbl_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		idle    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					state_d = in_action ? ST_READ : ST_PARSE;
				end
			end
			ST_PARSE: begin
				cmd.parse = 1'b1;
				state_d = ST_DONE;
				if (st.need_store) begin
					state_d = ST_SEARCH;
				end else if (st.need_eof) begin
					state_d = ST_EOF_WALK;
					cmd.eof_init = 1'b1;
				end
			end
			ST_SEARCH: begin
				if (st.cur_hit) begin
					state_d = ST_GAP;
				end else begin
					state_d = ST_OPEN;
					cmd.search_init = 1'b1;
				end
			end
			ST_OPEN: begin
				if (st.search_done) begin
					if (st.store_full) begin
						cmd.overflow = 1'b1;
						state_d = ST_DONE;
					end else begin
						cmd.open_blk = 1'b1;
						state_d = ST_GAP;
					end
				end else if (st.search_hit) begin
					cmd.search_sel = 1'b1;
					state_d = ST_GAP;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			ST_GAP: begin
				if (st.gap_more) begin
					cmd.gap_write = 1'b1;
				end else begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				cmd.data_write = 1'b1;
				state_d = ST_DONE;
			end
			ST_EOF_WALK: begin
				if (st.eof_done) begin
					cmd.eof_finish = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.eof_step = 1'b1;
				end
			end
			ST_READ: begin
				cmd.read_issue = 1'b1;
				state_d = ST_READ_WAIT;
			end
			ST_READ_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy) begin
					cmd.capture = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Only one memory-writing command at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.gap_write, cmd.data_write, cmd.eof_step}))
		else $error("ihbl_ctrl: conflicting write commands");
	// A word is captured only from the done state.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_IDLE)
		else $error("ihbl_ctrl: capture did not return to idle");
	// A read always passes through the wait state before completion.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read_issue |=> state_q == ST_READ_WAIT)
		else $error("ihbl_ctrl: read sequencing broken");

endmodule : ihbl_ctrl
`default_nettype wire

@@ rtl/core/ihbl_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX block loader datapath
// Record parser registers, block tables, byte memory and output register.
// ----------------------------------------------------------------------------
module ihbl_dpath #(
	parameter int unsigned BLOCK_BYTES = ihbl_pkg::BLOCK_BYTES_DEF,
	parameter int unsigned NUM_BLOCKS  = ihbl_pkg::NUM_BLOCKS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic [7:0]      in_char,
	input  wire logic [4:0]      in_rblk,
	input  wire logic [9:0]      in_roff,
	input  wire ihbl_pkg::cmd_t  cmd,
	output      ihbl_pkg::stat_t st,
	output      logic            o_echo_valid,
	output      logic [7:0]      o_echo_char,
	output      logic [4:0]      o_ready,
	output      logic [4:0]      o_open,
	output      logic            o_cks_err,
	output      logic            o_ovf_err,
	output      logic [7:0]      o_rdata,
	output      logic [21:0]     o_rbase,
	output      logic [10:0]     o_rfill
);
	import ihbl_pkg::*;

	localparam int unsigned OW = $clog2(BLOCK_BYTES);
	localparam int unsigned BW = $clog2(NUM_BLOCKS);
	localparam int unsigned FW = OW + 1;
	localparam int unsigned CW = BW + 1;
	localparam int unsigned AW = BW + OW;
	localparam int unsigned BASEW = 32 - OW;

	// Held input word.
	logic [7:0] ch_q;
	logic [4:0] rblk_q;
	logic [9:0] roff_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q   <= in_char;
			rblk_q <= in_rblk;
			roff_q <= in_roff;
		end
	end

	// Parser state.
	logic signed [9:0] pos_q;
	logic       nib_v_q;
	logic [3:0] nib_q;
	logic [7:0] hdr_q [4];
	logic [7:0] sum_q;
	logic [31:0] upper_q;
	logic [31:0] addr_q;
	logic [BW-1:0] cur_q;
	logic       sel_q;
	logic [CW-1:0] open_q;
	logic [CW-1:0] ready_q;
	logic [1:0] err_q;
	logic [7:0] byte_q;
	logic [CW-1:0] idx_q;

	// Block tables.
	logic [BASEW-1:0] base_mem [NUM_BLOCKS];
	logic [FW-1:0]    fill_mem [NUM_BLOCKS];
	logic [7:0]       byte_mem [NUM_BLOCKS*BLOCK_BYTES];

	// Hex digit decode.
	logic       is_hex;
	logic [3:0] digit;
	always_comb begin
		is_hex = 1'b1;
		digit  = 4'd0;
		if (ch_q >= 8'h30 && ch_q <= 8'h39) begin
			digit = 4'(ch_q - 8'h30);
		end else if (ch_q >= 8'h41 && ch_q <= 8'h46) begin
			digit = 4'(ch_q - 8'h37);
		end else if (ch_q >= 8'h61 && ch_q <= 8'h66) begin
			digit = 4'(ch_q - 8'h57);
		end else begin
			is_hex = 1'b0;
		end
	end

	logic [7:0] pbyte;
	logic [7:0] psum;
	assign pbyte = {nib_q, digit};
	assign psum  = sum_q + pbyte;

	// Address split.
	logic [BASEW-1:0] a_base;
	logic [OW-1:0]    a_off;
	logic [31:0]      rec_addr;
	assign rec_addr = upper_q | {16'd0, hdr_q[1], hdr_q[2]};

	logic [31:0] eff_addr;
	assign eff_addr = addr_q;
	assign a_base = eff_addr[31:OW];
	assign a_off  = eff_addr[OW-1:0];

	// Parse decisions.
	logic echo_d;
	logic p_store, p_eof;
	logic signed [10:0] rec_end;
	assign rec_end = 11'(hdr_q[0]) + 11'sd4;

	always_comb begin
		echo_d  = 1'b0;
		p_store = 1'b0;
		p_eof   = 1'b0;
		if (ch_q != CHAR_COLON && pos_q < 0) begin
			echo_d = !(pos_q == -10'sd1 && ch_q < CHAR_SPACE);
		end else if (ch_q != CHAR_COLON && !is_hex) begin
			echo_d = 1'b1;
		end else if (ch_q != CHAR_COLON && nib_v_q && pos_q >= 10'sd4) begin
			if (hdr_q[3] == REC_EOF) begin
				p_eof = 1'b1;
			end else if (hdr_q[3] == REC_DATA && 11'(pos_q) < rec_end) begin
				p_store = 1'b1;
			end
		end
	end

	logic [BW-1:0] idx_b;
	assign idx_b = idx_q[BW-1:0];
	logic [FW-1:0] cfill;
	assign cfill = fill_mem[cur_q];

	assign st.need_store  = p_store;
	assign st.need_eof    = p_eof;
	assign st.cur_hit     = sel_q && base_mem[cur_q] == a_base;
	assign st.search_done = idx_q >= open_q;
	assign st.search_hit  = base_mem[idx_b] == a_base;
	assign st.store_full  = open_q >= CW'(NUM_BLOCKS - 1);
	assign st.gap_more    = cfill < FW'(a_off);
	assign st.eof_done    = idx_q >= open_q;

	// Memory write port.
	logic          mw_en;
	logic [AW-1:0] mw_addr;
	logic [7:0]    mw_data;
	logic [FW-1:0] efill;
	assign efill = fill_mem[idx_b];
	always_comb begin
		mw_en   = 1'b0;
		mw_addr = {cur_q, cfill[OW-1:0]};
		mw_data = FILL_BYTE;
		if (cmd.gap_write) begin
			mw_en = 1'b1;
		end else if (cmd.data_write) begin
			mw_en   = cfill < FW'(BLOCK_BYTES);
			mw_data = byte_q;
		end else if (cmd.eof_step) begin
			mw_en   = efill < FW'(BLOCK_BYTES);
			mw_addr = {idx_b, efill[OW-1:0]};
		end
	end

	logic [7:0] rd_q;
	always_ff @(posedge clk) begin
		if (mw_en) begin
			byte_mem[mw_addr] <= mw_data;
		end
		if (cmd.read_issue) begin
			rd_q <= byte_mem[{rblk_q[BW-1:0], roff_q[OW-1:0]}];
		end
	end

	// Block table updates.
	always_ff @(posedge clk) begin
		if (cmd.open_blk) begin
			base_mem[open_q[BW-1:0]] <= a_base;
			fill_mem[open_q[BW-1:0]] <= '0;
		end else if (mw_en && !cmd.eof_step) begin
			fill_mem[cur_q] <= cfill + FW'(1);
		end else if (mw_en) begin
			fill_mem[idx_b] <= efill + FW'(1);
		end
	end

	// Parser and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= -10'sd1;
			nib_v_q <= 1'b0;
			nib_q   <= '0;
			for (int i = 0; i < 4; i++) hdr_q[i] <= '0;
			sum_q   <= '0;
			upper_q <= '0;
			addr_q  <= '0;
			cur_q   <= '0;
			sel_q   <= 1'b0;
			open_q  <= '0;
			ready_q <= '0;
			err_q   <= '0;
			byte_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.parse) begin
				if (ch_q == CHAR_COLON) begin
					pos_q   <= '0;
					nib_v_q <= 1'b0;
					sum_q   <= '0;
				end else if (pos_q < 0) begin
					if (pos_q == -10'sd1 && ch_q >= CHAR_SPACE) pos_q <= -10'sd2;
				end else if (!is_hex) begin
					pos_q <= -10'sd1;
				end else if (!nib_v_q) begin
					nib_q   <= digit;
					nib_v_q <= 1'b1;
				end else begin
					nib_v_q <= 1'b0;
					sum_q   <= psum;
					byte_q  <= pbyte;
					if (pos_q < 10'sd4) begin
						hdr_q[pos_q[1:0]] <= pbyte;
						pos_q <= pos_q + 10'sd1;
					end else if (hdr_q[3] == REC_EOF) begin
						pos_q <= -10'sd1;
					end else if (hdr_q[3] == REC_ELA) begin
						if (pos_q == 10'sd4) begin
							upper_q <= {pbyte, 24'd0};
							pos_q   <= pos_q + 10'sd1;
						end else begin
							upper_q[23:16] <= pbyte;
							pos_q <= -10'sd1;
						end
						ready_q <= '0;
					end else if (hdr_q[3] != REC_DATA) begin
						pos_q <= -10'sd1;
					end else begin
						if (pos_q == 10'sd4) addr_q <= rec_addr;
						if (11'(pos_q) >= rec_end) begin
							if (psum != 8'd0) err_q[0] <= 1'b1;
							pos_q <= -10'sd1;
						end
					end
				end
			end
			if (cmd.search_init) begin
				idx_q <= '0;
				sel_q <= 1'b0;
			end
			if (cmd.search_step) idx_q <= idx_q + CW'(1);
			if (cmd.search_sel) begin
				cur_q <= idx_b;
				sel_q <= 1'b1;
			end
			if (cmd.open_blk) begin
				cur_q  <= open_q[BW-1:0];
				sel_q  <= 1'b1;
				open_q <= open_q + CW'(1);
			end
			if (cmd.overflow) begin
				err_q[1] <= 1'b1;
				pos_q    <= -10'sd1;
			end
			if (cmd.data_write) begin
				pos_q  <= pos_q + 10'sd1;
				addr_q <= addr_q + 32'd1;
			end
			if (cmd.eof_init) idx_q <= '0;
			if (cmd.eof_step && efill >= FW'(BLOCK_BYTES)) idx_q <= idx_q + CW'(1);
			if (cmd.eof_finish) begin
				ready_q <= open_q;
				open_q  <= '0;
				sel_q   <= 1'b0;
			end
		end
	end

	// Output register.
	logic bad_blk;
	assign bad_blk = 32'(rblk_q) >= NUM_BLOCKS;
	logic rd_act_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_q <= 1'b0;
		end else if (in_fire) begin
			rd_act_q <= 1'b0;
		end else if (cmd.read_issue) begin
			rd_act_q <= 1'b1;
		end
	end

	logic echo_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q <= 1'b0;
		end else if (in_fire) begin
			echo_q <= 1'b0;
		end else if (cmd.parse) begin
			echo_q <= echo_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			o_echo_valid <= echo_q;
			o_echo_char  <= echo_q ? ch_q : 8'd0;
			o_ready      <= 5'(ready_q);
			o_open       <= 5'(open_q);
			o_cks_err    <= err_q[0];
			o_ovf_err    <= err_q[1];
			o_rdata      <= (rd_act_q && !bad_blk && 32'(roff_q) < BLOCK_BYTES) ? rd_q : 8'd0;
			o_rbase      <= (rd_act_q && !bad_blk) ? 22'(base_mem[rblk_q[BW-1:0]]) : 22'd0;
			o_rfill      <= (rd_act_q && !bad_blk) ? 11'(fill_mem[rblk_q[BW-1:0]]) : 11'd0;
		end
	end

	// Open count never reaches the block count.
	assert property (@(posedge clk) disable iff (!arst_n) open_q < CW'(NUM_BLOCKS))
		else $error("ihbl_dpath: open count overrun");
	// Sticky errors never clear.
	assert property (@(posedge clk) disable iff (!arst_n) $past(err_q[0]) |-> err_q[0])
		else $error("ihbl_dpath: checksum flag cleared");
	assert property (@(posedge clk) disable iff (!arst_n) $past(err_q[1]) |-> err_q[1])
		else $error("ihbl_dpath: overflow flag cleared");

endmodule : ihbl_dpath
`default_nettype wire

@@ rtl/core/intel_hex_block_loader_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Intel HEX block loader top level
// Parses received characters into Intel HEX records and loads data blocks.
// ----------------------------------------------------------------------------
// One input word is handled at a time; the next word is taken once the
// previous result has been loaded into the output register, so it may enter
// while that result still waits. A received character that stores nothing
// passes from idle through the parse and done states. A data byte adds
// a check of the selected block, the end of the gap fill and the store;
// when the selected block does not match, a search steps through the open
// blocks, and each gap byte is written with 0xff as a step of its own. An
// end-of-file record walks the open blocks one pad byte per cycle, with a
// step to move on to each next block and one to finish. A read passes the
// issue and wait states, as the memory read port is registered.
module intel_hex_block_loader_top #(
	parameter int unsigned BLOCK_BYTES = ihbl_pkg::BLOCK_BYTES_DEF,
	parameter int unsigned NUM_BLOCKS  = ihbl_pkg::NUM_BLOCKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic        s_tuser,  // action
	input  wire logic [23:0] s_tdata,  // rx_char[7:0], read_block[12:8], read_offset[22:13]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [63:0] m_tdata   // echo_valid, echo_char, blocks_ready, blocks_open,
	                                   // checksum_error, overflow_error, read_data,
	                                   // read_block_base, read_block_fill
);
	import ihbl_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  idle;
	logic  in_fire;
	logic  out_busy;

	logic        e_v, ce, oe;
	logic [7:0]  e_c, rdat;
	logic [4:0]  rdy, opn;
	logic [21:0] rbase;
	logic [10:0] rfill;

	assign s_tready = idle;
	assign in_fire  = s_tvalid && s_tready;
	assign out_busy = m_tvalid && !m_tready;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.capture) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	assign m_tdata = {2'b00, rfill, rbase, rdat, oe, ce, opn, rdy, e_c, e_v};

	ihbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_action (s_tuser),
		.out_busy  (out_busy),
		.st        (st),
		.cmd       (cmd),
		.idle      (idle)
	);

	ihbl_dpath #(
		.BLOCK_BYTES (BLOCK_BYTES),
		.NUM_BLOCKS  (NUM_BLOCKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.in_char      (s_tdata[7:0]),
		.in_rblk      (s_tdata[12:8]),
		.in_roff      (s_tdata[22:13]),
		.cmd          (cmd),
		.st           (st),
		.o_echo_valid (e_v),
		.o_echo_char  (e_c),
		.o_ready      (rdy),
		.o_open       (opn),
		.o_cks_err    (ce),
		.o_ovf_err    (oe),
		.o_rdata      (rdat),
		.o_rbase      (rbase),
		.o_rfill      (rfill)
	);

	// A word is accepted only while no result is being built.
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> !s_tready)
		else $error("top: accepted a word while busy");
	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("top: result changed under stall");
	// Capture never overwrites a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.capture |-> !out_busy)
		else $error("top: result overwritten");

endmodule : intel_hex_block_loader_top
`default_nettype wire

@@ tb/tb_intel_hex_block_loader_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX block loader testbench
// Drives received characters and stored-byte reads into the loader, mirrors
// the record parser and block store in a local predictor, and checks every
// output word against it under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_intel_hex_block_loader_top;
	import ihbl_pkg::*;

	localparam int BLK_SIZE = 1024;
	localparam int BLK_COUNT = 32;
	localparam bit ACT_CHAR = 1'b0;
	localparam bit ACT_READ = 1'b1;

	// Output word, lowest field in the lowest bits.
	typedef struct packed {
		logic [1:0]  pad;
		logic [10:0] fill;
		logic [21:0] base;
		logic [7:0]  rd;
		logic        ovf;
		logic        cks;
		logic [4:0]  opn;
		logic [4:0]  rdy;
		logic [7:0]  ech;
		logic        ev;
	} loader_out_t;

	// Directed stimulus row; typed rows override echo and read data.
	typedef struct {
		bit          act;
		logic [7:0]  ch;
		logic [4:0]  blk;
		logic [9:0]  off;
		bit          typed;
		logic        t_ev;
		logic [7:0]  t_ech;
		logic [7:0]  t_rd;
	} stim_row_t;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [23:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [63:0] m_tdata;

	intel_hex_block_loader_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Mirror of the parser and block store.
	int          rec_pos;
	bit          nib_valid;
	logic [3:0]  nib_high;
	logic [7:0]  hdr [4];
	logic [7:0]  rec_sum;
	logic [31:0] upper_addr, cur_addr;
	int          cur_blk;
	bit          blk_sel;
	logic [7:0]  store_mem [BLK_COUNT*BLK_SIZE];
	bit          byte_written [BLK_COUNT*BLK_SIZE];
	logic [31:0] blk_base [BLK_COUNT];
	int          blk_fill [BLK_COUNT];
	bit          blk_ever_open [BLK_COUNT];
	int          open_n, ready_n;
	bit          cks_flag, ovf_flag;

	loader_out_t expected_words [$];
	int          sender_idle_pct, recv_stall_pct;
	int          items_sent, words_checked, mismatches;
	int          reads_sent, eof_records, ovf_seen;

	function automatic void store_byte(logic [7:0] v);
		logic [31:0] base;
		int off;
		base = cur_addr / BLK_SIZE;
		off = cur_addr % BLK_SIZE;
		if (!blk_sel || blk_base[cur_blk] != base) begin
			blk_sel = 0;
			for (int i = 0; i < open_n; i++) begin
				if (blk_base[i] == base) begin
					cur_blk = i;
					blk_sel = 1;
					break;
				end
			end
			if (!blk_sel) begin
				if (open_n >= BLK_COUNT - 1) begin
					ovf_flag = 1;
					rec_pos = -1;
					return;
				end
				cur_blk = open_n++;
				blk_base[cur_blk] = base;
				blk_fill[cur_blk] = 0;
				blk_ever_open[cur_blk] = 1;
				blk_sel = 1;
			end
		end
		while (blk_fill[cur_blk] < off) begin
			store_mem[cur_blk*BLK_SIZE + blk_fill[cur_blk]] = FILL_BYTE;
			byte_written[cur_blk*BLK_SIZE + blk_fill[cur_blk]] = 1;
			blk_fill[cur_blk]++;
		end
		if (blk_fill[cur_blk] < BLK_SIZE) begin
			store_mem[cur_blk*BLK_SIZE + blk_fill[cur_blk]] = v;
			byte_written[cur_blk*BLK_SIZE + blk_fill[cur_blk]] = 1;
			blk_fill[cur_blk]++;
		end
		rec_pos++;
		cur_addr++;
	endfunction

	// Returns 1 when the character goes to the console.
	function automatic bit parse_char(logic [7:0] c);
		logic [3:0] d;
		logic [7:0] b;
		if (c == CHAR_COLON) begin
			rec_pos = 0;
			nib_valid = 0;
			rec_sum = 0;
			return 0;
		end
		if (rec_pos < 0) begin
			if (rec_pos == -1) begin
				if (c < CHAR_SPACE) return 0;
				rec_pos = -2;
			end
			return 1;
		end
		if (c >= "0" && c <= "9") d = 4'(c - "0");
		else if (c >= "A" && c <= "F") d = 4'(c - "A" + 10);
		else if (c >= "a" && c <= "f") d = 4'(c - "a" + 10);
		else begin
			rec_pos = -1;
			return 1;
		end
		if (!nib_valid) begin
			nib_high = d;
			nib_valid = 1;
			return 0;
		end
		nib_valid = 0;
		b = {nib_high, d};
		rec_sum = rec_sum + b;
		if (rec_pos < 4) begin
			hdr[rec_pos] = b;
			rec_pos++;
			return 0;
		end
		case (hdr[3])
			REC_DATA: ;
			REC_EOF: begin
				for (int i = 0; i < open_n; i++) begin
					while (blk_fill[i] < BLK_SIZE) begin
						store_mem[i*BLK_SIZE + blk_fill[i]] = FILL_BYTE;
						byte_written[i*BLK_SIZE + blk_fill[i]] = 1;
						blk_fill[i]++;
					end
				end
				ready_n = open_n;
				open_n = 0;
				blk_sel = 0;
				rec_pos = -1;
				return 0;
			end
			REC_ELA: begin
				if (rec_pos == 4) begin
					upper_addr = {b, 24'h0};
					rec_pos++;
				end else begin
					upper_addr = upper_addr | {8'h0, b, 16'h0};
					rec_pos = -1;
				end
				ready_n = 0;
				return 0;
			end
			default: begin
				rec_pos = -1;
				return 0;
			end
		endcase
		if (rec_pos == 4) cur_addr = upper_addr | {16'h0, hdr[1], hdr[2]};
		if (rec_pos >= int'(hdr[0]) + 4) begin
			if (rec_sum != 0) cks_flag = 1;
			rec_pos = -1;
			return 0;
		end
		store_byte(b);
		return 0;
	endfunction

	function automatic loader_out_t predict_word(bit act, logic [7:0] c, logic [4:0] blk,
	                                             logic [9:0] off);
		loader_out_t r;
		r = '0;
		if (act == ACT_CHAR) begin
			if (parse_char(c)) begin
				r.ev = 1;
				r.ech = c;
			end
		end else begin
			r.base = blk_base[blk][21:0];
			r.fill = 11'(blk_fill[blk]);
			r.rd = store_mem[blk*BLK_SIZE + off];
		end
		r.rdy = 5'(ready_n);
		r.opn = 5'(open_n);
		r.cks = cks_flag;
		r.ovf = ovf_flag;
		return r;
	endfunction

	// Drive one word at the falling edge and hold it until accepted.
	task automatic send_word(bit act, logic [7:0] c, logic [4:0] blk, logic [9:0] off,
	                         bit typed = 0, logic t_ev = 0, logic [7:0] t_ech = 0,
	                         logic [7:0] t_rd = 0);
		loader_out_t w;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		w = predict_word(act, c, blk, off);
		if (typed) begin
			w.ev = t_ev;
			w.ech = t_ech;
			w.rd = t_rd;
		end
		expected_words.push_back(w);
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {1'b0, off, blk, c};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
		if (act == ACT_READ) reads_sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send_word(ACT_CHAR, c, 5'($urandom), 10'($urandom));
	endtask

	function automatic logic [7:0] hex_digit(logic [3:0] v);
		if (v < 10) return 8'("0" + v);
		return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
	endfunction

	task automatic send_hex_byte(logic [7:0] b);
		send_char(hex_digit(b[7:4]));
		send_char(hex_digit(b[3:0]));
	endtask

	// Whole record with its checksum; a nonzero corrupt value spoils it.
	task automatic send_record(logic [7:0] cnt, logic [15:0] addr, logic [7:0] rtype,
	                           logic [7:0] payload [$], logic [7:0] corrupt = 0);
		logic [7:0] sum;
		sum = cnt + addr[15:8] + addr[7:0] + rtype;
		send_char(CHAR_COLON);
		send_hex_byte(cnt);
		send_hex_byte(addr[15:8]);
		send_hex_byte(addr[7:0]);
		send_hex_byte(rtype);
		foreach (payload[i]) begin
			send_hex_byte(payload[i]);
			sum = sum + payload[i];
		end
		send_hex_byte(8'(-sum) ^ corrupt);
		if ($urandom_range(2) == 0) begin
			send_char(8'h0d);
			send_char(8'h0a);
		end
	endtask

	task automatic send_ela(logic [15:0] upper);
		logic [7:0] p [$];
		p = '{upper[15:8], upper[7:0]};
		send_record(8'd2, 16'h0, REC_ELA, p);
	endtask

	task automatic send_eof();
		logic [7:0] p [$];
		p = '{};
		send_record(8'd0, 16'h0, REC_EOF, p);
		eof_records++;
	endtask

	// Read a stored byte that has been written since reset, if one of up to 40 random picks finds one.
	task automatic send_read();
		int b, o;
		for (int t = 0; t < 40; t++) begin
			b = $urandom_range(BLK_COUNT - 1);
			o = ($urandom_range(3) == 0) ? BLK_SIZE - 1 - $urandom_range(3)
			                            : $urandom_range(BLK_SIZE - 1);
			if (blk_ever_open[b] && byte_written[b*BLK_SIZE + o]) begin
				send_word(ACT_READ, 8'($urandom), 5'(b), 10'(o));
				return;
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
	endtask

	// Result side: stall pattern and checking.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		loader_out_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("ERROR: unexpected word %h", got);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (got.ev !== want.ev || got.ech !== want.ech || got.rdy !== want.rdy ||
				    got.opn !== want.opn || got.cks !== want.cks || got.ovf !== want.ovf ||
				    got.rd !== want.rd || got.base !== want.base || got.fill !== want.fill) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: word %0d echo %b/%h ready %0d open %0d err %b%b rd %h base %h fill %0d, expected echo %b/%h ready %0d open %0d err %b%b rd %h base %h fill %0d",
							words_checked, got.ev, got.ech, got.rdy, got.opn, got.ovf,
							got.cks, got.rd, got.base, got.fill, want.ev, want.ech, want.rdy,
							want.opn, want.ovf, want.cks, want.rd, want.base, want.fill);
				end
				if (got.ovf === 1'b1) ovf_seen++;
			end
		end
	end

	// Directed part: console echo rules, one data record, a read back, then a record broken off by a non-hex character.
	stim_row_t directed [] = '{
		'{ACT_CHAR, 8'h00, 5'd0, 10'd0, 1, 1'b0, 8'h00, 8'h00},
		'{ACT_CHAR, 8'h41, 5'd31, 10'd1023, 1, 1'b1, 8'h41, 8'h00},
		'{ACT_CHAR, 8'h01, 5'd0, 10'd0, 1, 1'b1, 8'h01, 8'h00},
		'{ACT_CHAR, 8'hff, 5'd0, 10'd0, 1, 1'b1, 8'hff, 8'h00},
		'{ACT_CHAR, ":", 5'd0, 10'd0, 1, 1'b0, 8'h00, 8'h00},
		'{ACT_CHAR, "0", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "1", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "0", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "0", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "0", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "0", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "0", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "0", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "A", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "b", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "5", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "4", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, 8'h0a, 5'd0, 10'd0, 1, 1'b0, 8'h00, 8'h00},
		'{ACT_READ, 8'hff, 5'd0, 10'd0, 1, 1'b0, 8'h00, 8'hab},
		'{ACT_CHAR, ":", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "0", 5'd0, 10'd0, 0, 0, 0, 0},
		'{ACT_CHAR, "z", 5'd0, 10'd0, 1, 1'b1, "z", 8'h00}
	};

	initial begin
		logic [7:0] p [$];
		logic [15:0] upper_pick;
		int sel, n, pool;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		rec_pos = -1;
		nib_valid = 0;
		nib_high = 0;
		foreach (hdr[i]) hdr[i] = 0;
		rec_sum = 0;
		upper_addr = 0;
		cur_addr = 0;
		cur_blk = 0;
		blk_sel = 0;
		foreach (store_mem[i]) begin
			store_mem[i] = 0;
			byte_written[i] = 0;
		end
		foreach (blk_base[i]) begin
			blk_base[i] = 0;
			blk_fill[i] = 0;
			blk_ever_open[i] = 0;
		end
		open_n = 0;
		ready_n = 0;
		cks_flag = 0;
		ovf_flag = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_word(directed[i].act, directed[i].ch, directed[i].blk, directed[i].off,
			          directed[i].typed, directed[i].t_ev, directed[i].t_ech, directed[i].t_rd);
		drain_results();

		// Random records in four pacing phases.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin sender_idle_pct = 0; recv_stall_pct = 0; end
				1: begin sender_idle_pct = 62; recv_stall_pct = 0; end
				2: begin sender_idle_pct = 0; recv_stall_pct = 62; end
				default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			while (items_sent < 25 + (ph + 1) * 320) begin
				sel = $urandom_range(99);
				if (ph == 2 && ovf_flag == 0) begin
					// Open more blocks than the store holds, then close the file.
					upper_pick = 16'($urandom_range(1, 16'hffff));
					send_ela(upper_pick);
					for (int k = 0; k < BLK_COUNT + 1; k++) begin
						p = '{8'($urandom)};
						send_record(8'd1, 16'(k * BLK_SIZE + $urandom_range(3)), REC_DATA, p);
					end
					send_read();
					send_eof();
					send_read();
				end else if (sel < 50) begin
					n = ($urandom_range(9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4);
					p = '{};
					for (int k = 0; k < n; k++) p.push_back(8'($urandom));
					pool = $urandom_range(4);
					send_record(8'(n), {pool == 4 ? 6'h3f : 6'(pool),
					            ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(40))},
					            REC_DATA, p, ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h0);
				end else if (sel < 57) begin
					case ($urandom_range(2))
						0: send_ela(16'h0000);
						1: send_ela(16'hffff);
						default: send_ela(16'($urandom));
					endcase
				end else if (sel < 62) begin
					send_eof();
				end else if (sel < 66) begin
					p = '{8'($urandom), 8'($urandom)};
					send_record(8'd2, 16'($urandom), 8'($urandom_range(5, 255)), p);
				end else if (sel < 72) begin
					// Record broken off by a character that is not hex.
					send_char(CHAR_COLON);
					n = $urandom_range(1, 12);
					for (int k = 0; k < n; k++) send_char(hex_digit(4'($urandom)));
					send_char(($urandom_range(1)) ? "G" : 8'h0d);
				end else if (sel < 84) begin
					n = $urandom_range(1, 5);
					for (int k = 0; k < n; k++) send_char(8'($urandom));
				end else begin
					send_read();
				end
			end
			// Sender holds off until everything outstanding has come back.
			drain_results();
		end

		s_tvalid <= 1'b0;
		drain_results();
		repeat (200) @(negedge clk);
		$display("Covered %0d words (%0d reads, %0d end-of-file records), %0d results checked,",
		         items_sent, reads_sent, eof_records, words_checked);
		$display("overflow flag seen on %0d results, under four idle and stall patterns.",
		         ovf_seen);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_words.size());
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("Timeout with %0d results outstanding", expected_words.size());
		$display("tb: failure");
		$finish;
	end

endmodule
